/* hw/rtl/pfc_pkg.sv */
package pfc_pkg;

  localparam int unsigned PwmPeriodCounts = 4096;
  localparam int unsigned DutyMargin      = 1073742;

  localparam logic signed [31:0] Q30One   = 32'sd1073741824;
  localparam logic signed [31:0] LeakQ30  = 32'sd1068373115;
  localparam logic signed [31:0] DutyLim  = 32'(1073741824 - DutyMargin);
  localparam logic [30:0]        CurKiRst = 31'd13107;

  localparam logic [7:0] RegCapSetpoint = 8'd0;
  localparam logic [7:0] RegCapKp       = 8'd1;
  localparam logic [7:0] RegCapKi       = 8'd2;
  localparam logic [7:0] RegCurKi       = 8'd3;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [31:0] duty;
    logic [15:0]        cmp;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

/* hw/rtl/pfc_ifs.sv */
interface pfc_in_if;
  logic               valid;
  logic               ready;
  logic               clear_accumulators;
  logic               pwm_enabled;
  logic signed [31:0] cap_voltage_mean;
  logic signed [31:0] ref_a;
  logic signed [31:0] ref_b;
  logic signed [31:0] ref_c;
  logic [30:0]        ref_rms_a;
  logic [30:0]        ref_rms_b;
  logic [30:0]        ref_rms_c;
  logic signed [31:0] cur_dev_a;
  logic signed [31:0] cur_dev_b;
  logic signed [31:0] cur_dev_c;
  modport source(output valid, clear_accumulators, pwm_enabled, cap_voltage_mean,
                 ref_a, ref_b, ref_c, ref_rms_a, ref_rms_b, ref_rms_c,
                 cur_dev_a, cur_dev_b, cur_dev_c, input ready);
  modport sink(input valid, clear_accumulators, pwm_enabled, cap_voltage_mean,
               ref_a, ref_b, ref_c, ref_rms_a, ref_rms_b, ref_rms_c,
               cur_dev_a, cur_dev_b, cur_dev_c, output ready);
endinterface

interface pfc_out_if;
  logic               valid;
  logic               ready;
  logic               drive_valid;
  logic signed [31:0] duty_a;
  logic signed [31:0] duty_b;
  logic signed [31:0] duty_c;
  logic [15:0]        compare_a;
  logic [15:0]        compare_b;
  logic [15:0]        compare_c;
  modport source(output valid, drive_valid, duty_a, duty_b, duty_c,
                 compare_a, compare_b, compare_c, input ready);
  modport sink(input valid, drive_valid, duty_a, duty_b, duty_c,
               compare_a, compare_b, compare_c, output ready);
endinterface

interface pfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/pfc_lane.sv */
module pfc_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfc_pkg::lane_ctl_t    ctl_i,
  input  logic signed [31:0]    vl_i,
  input  logic signed [31:0]    ref_i,
  input  logic [30:0]           rms_i,
  input  logic signed [31:0]    dev_i,
  input  logic [30:0]           cur_ki_i,
  output logic                  busy_o,
  output pfc_pkg::lane_res_t    res_o
);

  typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_ERR, L_KI, L_LEAK} lane_state_e;

  lane_state_e        state_q;
  logic signed [31:0] ci_q;
  logic [63:0]        div_q;
  logic [31:0]        rem_q;
  logic [5:0]         cnt_q;
  logic               neg_q;
  logic signed [31:0] err_q;
  logic signed [31:0] raw_q;
  pfc_pkg::lane_res_t res_q;

  logic signed [63:0] prod;
  logic [63:0]        mag;
  logic [31:0]        rem_sh;
  logic               ge;
  logic signed [31:0] ivl;
  logic signed [63:0] ki_prod;
  logic signed [63:0] leak_prod;
  logic signed [63:0] leaked;
  logic signed [31:0] duty;
  logic [32:0]        diff;
  logic [47:0]        cmp_prod;

  always_comb begin
    prod   = vl_i * ref_i;
    mag    = prod[63] ? 64'(0 - prod) : prod;
    rem_sh = {rem_q[30:0], div_q[63]};
    ge     = rem_sh >= {1'b0, rms_i};
    if (neg_q) begin
      ivl = (div_q > 64'd2147483648) ? 32'sh80000000 : 32'(0 - div_q[31:0]);
    end else begin
      ivl = (div_q > 64'd2147483647) ? 32'sh7fffffff : div_q[31:0];
    end
    ki_prod   = $signed({1'b0, cur_ki_i}) * err_q;
    leak_prod = raw_q * pfc_pkg::LeakQ30 + 64'sd536870912;
    leaked    = leak_prod >>> 30;
    if (raw_q > pfc_pkg::DutyLim) begin
      duty = pfc_pkg::DutyLim;
    end else if (raw_q < -pfc_pkg::DutyLim) begin
      duty = -pfc_pkg::DutyLim;
    end else begin
      duty = raw_q;
    end
    diff     = 33'(34'sd1073741824 - 34'(duty));
    cmp_prod = 48'(pfc_pkg::PwmPeriodCounts) * 48'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      ci_q    <= '0;
    end else begin
      if (ctl_i.clear) begin
        ci_q <= '0;
      end
      case (state_q)
        L_IDLE: begin
          if (ctl_i.start) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          neg_q <= prod[63];
          rem_q <= '0;
          cnt_q <= '0;
          if (rms_i == '0) begin
            div_q   <= '0;
            state_q <= L_ERR;
          end else begin
            div_q   <= mag;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem_q <= ge ? 32'(rem_sh - {1'b0, rms_i}) : rem_sh;
          div_q <= {div_q[62:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= L_ERR;
          end
        end
        L_ERR: begin
          err_q   <= pfc_pkg::sat32(66'(ivl) + 66'(dev_i));
          state_q <= L_KI;
        end
        L_KI: begin
          raw_q   <= pfc_pkg::sat32(66'(ci_q) + 66'(ki_prod >>> 2));
          state_q <= L_LEAK;
        end
        L_LEAK: begin
          if (leaked > 64'(pfc_pkg::Q30One)) begin
            ci_q <= pfc_pkg::Q30One;
          end else if (leaked < -64'(pfc_pkg::Q30One)) begin
            ci_q <= -pfc_pkg::Q30One;
          end else begin
            ci_q <= leaked[31:0];
          end
          res_q.duty <= duty;
          res_q.cmp  <= cmp_prod[46:31];
          state_q    <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign busy_o = state_q != L_IDLE;
  assign res_o  = res_q;

endmodule

/* hw/rtl/three_phase_pfc_current_loop.sv */
// Three-phase PFC dual-loop current controller.
// in_i: one control sample per transaction (valid/ready). out_o:
// exactly one result transaction per sample. cfg_i: register writes
// (0 setpoint, 1 outer kp, 2 outer ki, 3 inner ki); always ready, take
// effect at once, and must only be issued while the block is idle.
// Sequence: with PWM off an accepted sample goes straight to the merge
// step. With PWM on the outer loop and lane start come first, then per
// phase the lane multiply, 64 divider steps (skipped when that phase's
// RMS is zero) and the error, integrator and leak steps, then the merge
// into the output register. The three lanes run in parallel, each with
// its own bit-serial divider.
// Throughput: one sample at a time; the next is taken once the result is
// in the output register, so it may be accepted while the result waits.
// Stall: the result register holds until out_o.ready; a finished sample
// waits in the merge step until the register frees up.
// Reset: integrators zero, gains and setpoint at reset values, no output.
module three_phase_pfc_current_loop (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfc_in_if.sink    in_i,
  pfc_out_if.source out_o,
  pfc_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_KI, ST_KP, ST_VL, ST_START, ST_LANES, ST_PUSH
  } top_state_e;

  top_state_e         state_q;
  logic [30:0]        setpoint_q, kp_q, ki_q, cur_ki_q;
  logic signed [31:0] vi_q, vl_q;
  logic signed [32:0] e_q;
  logic signed [64:0] mul_q;
  logic               pwm_q;
  logic signed [31:0] ref_q [3];
  logic [30:0]        rms_q [3];
  logic signed [31:0] dev_q [3];

  logic               out_valid_q, drive_q;
  pfc_pkg::lane_res_t out_res_q [3];

  pfc_pkg::lane_ctl_t ctl;
  pfc_pkg::lane_res_t lres [3];
  logic [2:0]         busy;
  logic               accept;
  logic               out_free;

  assign in_i.ready  = state_q == ST_IDLE;
  assign accept      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign ctl.start   = state_q == ST_START;
  assign ctl.clear   = accept && in_i.clear_accumulators;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pfc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .vl_i     (vl_q),
      .ref_i    (ref_q[g]),
      .rms_i    (rms_q[g]),
      .dev_i    (dev_q[g]),
      .cur_ki_i (cur_ki_q),
      .busy_o   (busy[g]),
      .res_o    (lres[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      kp_q       <= '0;
      ki_q       <= '0;
      cur_ki_q   <= pfc_pkg::CurKiRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pfc_pkg::RegCapSetpoint: setpoint_q <= cfg_i.data[30:0];
        pfc_pkg::RegCapKp:       kp_q       <= cfg_i.data[30:0];
        pfc_pkg::RegCapKi:       ki_q       <= cfg_i.data[30:0];
        pfc_pkg::RegCurKi:       cur_ki_q   <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_i.clear_accumulators) begin
              vi_q <= '0;
            end
            pwm_q    <= in_i.pwm_enabled;
            e_q      <= $signed({2'b00, setpoint_q}) - 33'(in_i.cap_voltage_mean);
            ref_q[0] <= in_i.ref_a;
            ref_q[1] <= in_i.ref_b;
            ref_q[2] <= in_i.ref_c;
            rms_q[0] <= in_i.ref_rms_a;
            rms_q[1] <= in_i.ref_rms_b;
            rms_q[2] <= in_i.ref_rms_c;
            dev_q[0] <= in_i.cur_dev_a;
            dev_q[1] <= in_i.cur_dev_b;
            dev_q[2] <= in_i.cur_dev_c;
            state_q  <= in_i.pwm_enabled ? ST_KI : ST_PUSH;
          end
        end
        ST_KI: begin
          mul_q   <= $signed({1'b0, ki_q}) * e_q;
          state_q <= ST_KP;
        end
        ST_KP: begin
          vi_q    <= pfc_pkg::sat32(66'(vi_q) + 66'(mul_q >>> 16));
          mul_q   <= $signed({1'b0, kp_q}) * e_q;
          state_q <= ST_VL;
        end
        ST_VL: begin
          vl_q    <= pfc_pkg::sat32(66'(mul_q >>> 16) + 66'(vi_q));
          state_q <= ST_START;
        end
        ST_START: state_q <= ST_LANES;
        ST_LANES: begin
          if (busy == '0) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          // merge lane results into the output register
          if (out_free) begin
            out_valid_q <= 1'b1;
            drive_q     <= pwm_q;
            for (int k = 0; k < 3; k++) begin
              out_res_q[k] <= pwm_q ? lres[k] : '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_valid = drive_q;
  assign out_o.duty_a      = out_res_q[0].duty;
  assign out_o.duty_b      = out_res_q[1].duty;
  assign out_o.duty_c      = out_res_q[2].duty;
  assign out_o.compare_a   = out_res_q[0].cmp;
  assign out_o.compare_b   = out_res_q[1].cmp;
  assign out_o.compare_c   = out_res_q[2].cmp;

endmodule

/* hw/rtl/pfc_checker.sv */
module pfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               drive_valid_i,
  input logic signed [31:0] duty_a_i,
  input logic [15:0]        compare_a_i,
  input logic [15:0]        compare_b_i,
  input logic [15:0]        compare_c_i
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !drive_valid_i |-> duty_a_i == '0 && compare_a_i == '0 &&
    compare_b_i == '0 && compare_c_i == '0) else $error("idle result not zero");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> duty_a_i <= pfc_pkg::DutyLim && duty_a_i >= -pfc_pkg::DutyLim)
    else $error("duty out of range");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(compare_a_i) <= pfc_pkg::PwmPeriodCounts &&
    32'(compare_b_i) <= pfc_pkg::PwmPeriodCounts &&
    32'(compare_c_i) <= pfc_pkg::PwmPeriodCounts) else $error("compare out of range");

endmodule

bind three_phase_pfc_current_loop pfc_checker u_pfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .drive_valid_i (out_o.drive_valid),
  .duty_a_i      (out_o.duty_a),
  .compare_a_i   (out_o.compare_a),
  .compare_b_i   (out_o.compare_b),
  .compare_c_i   (out_o.compare_c)
);

/* tb/sv/tb_three_phase_pfc_current_loop.sv */
module tb_three_phase_pfc_current_loop;
  import pfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               clr;
    logic               pwm;
    logic signed [31:0] vmean;
    logic signed [31:0] vref[3];
    logic [30:0]        rms[3];
    logic signed [31:0] idev[3];
  } sample_t;

  typedef struct {
    logic               drv;
    logic signed [31:0] duty[3];
    logic [15:0]        cmp[3];
  } drive_t;

  int unsigned mismatches = 0;

  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  class pfc_scoreboard;
    longint unsigned setpoint, kp, ki_v, ki_c;
    longint          v_int;
    longint          c_int[3];
    drive_t          pending[$];
    int unsigned     n_checked, n_driven, n_idle;

    function new();
      setpoint = 0; kp = 0; ki_v = 0; ki_c = CurKiRst;
      v_int = 0; c_int = '{0, 0, 0};
    endfunction

    function automatic longint sat(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // arithmetic shift on longint floors, matching the spec
    function automatic longint fdiv(input longint v, input int n);
      return v >>> n;
    endfunction

    function void write_reg(input logic [7:0] idx, input logic [31:0] val);
      longint unsigned v;
      v = val[30:0];
      case (idx)
        RegCapSetpoint: setpoint = v;
        RegCapKp:       kp = v;
        RegCapKi:       ki_v = v;
        RegCurKi:       ki_c = v;
        default: ;
      endcase
    endfunction

    function void note_sample(input sample_t s);
      drive_t d;
      longint e, vl, ivl, err, raw, lk, lim, p, q;
      longint unsigned mag;
      if (s.clr) begin
        v_int = 0; c_int = '{0, 0, 0};
      end
      d.drv = s.pwm;
      d.duty = '{0, 0, 0};
      d.cmp = '{0, 0, 0};
      if (s.pwm) begin
        e = longint'(setpoint) - longint'(s.vmean);
        v_int = sat(v_int + fdiv(longint'(ki_v) * e, 16));
        vl = sat(fdiv(longint'(kp) * e, 16) + v_int);
        lim = 64'sd1073741824 - DutyMargin;
        for (int k = 0; k < 3; k++) begin
          if (s.rms[k] == 0) ivl = 0;
          else begin
            p = vl * longint'(s.vref[k]);
            mag = (p < 0) ? -p : p;
            q = longint'(mag / s.rms[k]);
            if (p < 0) ivl = (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
            else ivl = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
          end
          err = sat(ivl + longint'(s.idev[k]));
          raw = sat(c_int[k] + fdiv(longint'(ki_c) * err, 2));
          lk = fdiv(raw * 64'sd1068373115 + (64'sd1 << 29), 30);
          c_int[k] = (lk > 64'sd1073741824) ? 64'sd1073741824 :
                     (lk < -64'sd1073741824) ? -64'sd1073741824 : lk;
          if (raw > lim) raw = lim;
          if (raw < -lim) raw = -lim;
          d.duty[k] = raw[31:0];
          d.cmp[k] = 16'((longint'(PwmPeriodCounts) * (64'sd1073741824 - raw)) >>> 31);
        end
      end
      pending.push_back(d);
    endfunction

    task check_drive(input drive_t got);
      drive_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (w.drv) n_driven++; else n_idle++;
      if (got.drv !== w.drv) report("drive_valid", got.drv, w.drv);
      for (int k = 0; k < 3; k++) begin
        if (got.duty[k] !== w.duty[k]) report($sformatf("duty[%0d]", k), got.duty[k], w.duty[k]);
        if (got.cmp[k] !== w.cmp[k]) report($sformatf("compare[%0d]", k), got.cmp[k], w.cmp[k]);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  pfc_in_if  in_if();
  pfc_out_if out_if();
  pfc_cfg_if cfg_if();

  three_phase_pfc_current_loop DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_i(cfg_if.sink)
  );

  pfc_scoreboard sb = new();
  longint unsigned cycles = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] rand_edge32();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // plausible operating point in Q16.16 so the loops do not just saturate; wild picks edge values
  function automatic sample_t rand_sample(input bit wild);
    sample_t s;
    s.clr = ($urandom_range(0, 40) == 0);
    s.pwm = ($urandom_range(0, 9) != 0);
    for (int k = 0; k < 3; k++) begin
      if (wild) begin
        s.vref[k] = rand_edge32();
        s.rms[k]  = ($urandom_range(0, 9) == 0) ? 31'd0 : 31'(rand_edge32());
        s.idev[k] = rand_edge32();
      end else begin
        s.vref[k] = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        s.rms[k]  = ($urandom_range(0, 30) == 0) ? 31'd0 : 31'($urandom_range(1, 32'h0030_0000));
        s.idev[k] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      end
    end
    s.vmean = wild ? rand_edge32() : $signed(sb.setpoint[31:0]) +
              $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    return s;
  endfunction

  // valid stays high after the transaction; gaps and drains drop it
  task automatic send_sample(input sample_t s);
    in_if.valid <= 1'b1;
    in_if.clear_accumulators <= s.clr;
    in_if.pwm_enabled <= s.pwm;
    in_if.cap_voltage_mean <= s.vmean;
    in_if.ref_a <= s.vref[0]; in_if.ref_b <= s.vref[1]; in_if.ref_c <= s.vref[2];
    in_if.ref_rms_a <= s.rms[0]; in_if.ref_rms_b <= s.rms[1]; in_if.ref_rms_c <= s.rms[2];
    in_if.cur_dev_a <= s.idev[0]; in_if.cur_dev_b <= s.idev[1];
    in_if.cur_dev_c <= s.idev[2];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic source_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // valid stays high after the write; the caller drops it
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic set_gains(input logic [31:0] sp, input logic [31:0] p,
                           input logic [31:0] vi, input logic [31:0] ci);
    write_reg(RegCapSetpoint, sp);
    write_reg(RegCapKp, p);
    write_reg(RegCapKi, vi);
    write_reg(RegCurKi, ci);
    cfg_if.valid <= 1'b0;
  endtask

  // sink: random stalls, plus one long hold-off requested by the sender
  initial begin
    int n;
    drive_t got;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 120) :
          (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
      if (n != 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.drv = out_if.drive_valid;
        got.duty = '{out_if.duty_a, out_if.duty_b, out_if.duty_c};
        got.cmp = '{out_if.compare_a, out_if.compare_b, out_if.compare_c};
        sb.check_drive(got);
      end
    end
  end

  initial begin
    sample_t s;
    in_if.valid = 1'b0;
    in_if.clear_accumulators = 1'b0; in_if.pwm_enabled = 1'b0;
    in_if.cap_voltage_mean = '0;
    in_if.ref_a = '0; in_if.ref_b = '0; in_if.ref_c = '0;
    in_if.ref_rms_a = '0; in_if.ref_rms_b = '0; in_if.ref_rms_c = '0;
    in_if.cur_dev_a = '0; in_if.cur_dev_b = '0; in_if.cur_dev_c = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset gains, PWM off, clear, zero RMS, field extremes
    s = rand_sample(1'b0); s.pwm = 1'b1; s.clr = 1'b0; send_sample(s);
    s.pwm = 1'b0; send_sample(s);
    s.clr = 1'b1; send_sample(s);
    s.pwm = 1'b1; s.clr = 1'b0; s.rms = '{0, 0, 0}; send_sample(s);
    drain();
    set_gains(32'h0190_0000, 32'h0000_8000, 32'h0000_1000, 32'h0000_3333);
    for (int i = 0; i < 8; i++) begin
      s = rand_sample(1'b1); s.pwm = 1'b1; s.clr = (i == 5);
      s.vmean = (i[0]) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      if (i[1]) begin
        s.vref = '{32'sh8000_0000, 32'sh7fff_ffff, 0};
      end else begin
        s.vref = '{32'sh7fff_ffff, 32'sh8000_0000, -1};
      end
      if (i[2]) begin
        s.rms = '{31'h7fff_ffff, 31'd1, 31'd0};
      end else begin
        s.rms = '{31'd1, 31'h7fff_ffff, 31'd1};
      end
      s.idev = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh1234_5678};
      send_sample(s);
    end
    s.pwm = 1'b0; s.clr = 1'b1; send_sample(s);
    drain();
    set_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(1'b1));
    drain();
    write_reg(8'd7, 32'hffff_ffff);
    cfg_if.valid <= 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: set_gains(32'h0190_0000, 32'h0000_4000, 32'h0000_0800, 32'h0000_3333);
        1: set_gains(32'h0, 32'h0, 32'h0, 32'h0);
        2: set_gains($urandom(), $urandom(), $urandom(), $urandom());
        3: set_gains(32'h0200_0000, 32'h0002_0000, 32'h0000_0100, 32'h0001_0000);
        default: set_gains(32'h7fff_ffff, 32'h0001_0000, 32'h0, 32'h7fff_ffff);
      endcase
      for (int i = 0; i < 235; i++) begin
        if (phase == 1 && i == 20) long_hold = 1'b1;
        if (phase == 2 && i == 100) drain();
        send_sample(rand_sample($urandom_range(0, 4) == 0));
        if (!(phase == 1 && i >= 20 && i < 30)) source_gap();
      end
    end
    drain();
    stim_done = 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    $display("%0d results checked: %0d with PWM on, %0d with PWM off",
             sb.n_checked, sb.n_driven, sb.n_idle);
    $display("covered gain sweeps, clears, zero RMS, stalls and full-scale inputs");
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
